>>> sv/hcbp_pkg.sv
// Shared types and constants of the Huffman code bit packer.
package hcbp_pkg;

  localparam int unsigned SymW     = 8;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned LenInW   = 5;
  localparam int unsigned ZeroW    = 4;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned TblDepth = 256;
  localparam int unsigned WinW     = 24;
  localparam int unsigned CntW     = 5;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;
  localparam int unsigned QCntW    = 3;

  typedef enum logic [1:0] {
    OP_LOAD      = 2'd0,
    OP_ENCODE    = 2'd1,
    OP_ZERO_FILL = 2'd2
  } op_e;

  typedef struct packed {
    logic [ByteW-1:0] packed_byte;
    logic             last_of_run;
    logic             symbol_missing;
  } out_word_t;

endpackage

>>> sv/hcbp_if.sv
// Valid/ready channel interfaces for the input and output words of the packer.
interface hcbp_in_if;
  import hcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [SymW-1:0]   symbol;
  logic [ValueW-1:0] code_value;
  logic [LenInW-1:0] code_length;
  logic [ZeroW-1:0]  zero_count;

  modport source (
    output valid, opcode, symbol, code_value, code_length, zero_count,
    input  ready
  );
  modport sink (
    input  valid, opcode, symbol, code_value, code_length, zero_count,
    output ready
  );
endinterface

interface hcbp_out_if;
  import hcbp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] packed_byte;
  logic             last_of_run;
  logic             symbol_missing;

  modport source (
    output valid, packed_byte, last_of_run, symbol_missing,
    input  ready
  );
  modport sink (
    input  valid, packed_byte, last_of_run, symbol_missing,
    output ready
  );
endinterface

>>> sv/hcbp_ram.sv
// Generic single-port-write, registered-read RAM.
module hcbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/huffman_code_bit_packer.sv
// Huffman code bit packer: code table, bit accumulator and output word queue.
// Path: an accepted word is registered in stage 1 together with its table read, then
// written to the output queue once the queue has room, and offered on the output channel.
// Throughput: one input word per cycle; input stalls while a merged word waits and the
// four-entry output queue holds more than two bytes; it drains one byte per cycle while ready.
// Reset: clears all table valid bits, the accumulator, the bit position and the queue.
module huffman_code_bit_packer #(
  parameter int unsigned MAX_CODE_LEN = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcbp_in_if.sink   in_i,
  hcbp_out_if.source out_o
);
  import hcbp_pkg::*;

  localparam int unsigned CodeW = (MAX_CODE_LEN < ValueW) ? MAX_CODE_LEN : ValueW;
  localparam int unsigned LenW  = $clog2(CodeW + 1);
  localparam int unsigned EntW  = CodeW + LenW;

  logic                accept;
  logic                s1_go;
  logic [LenW-1:0]     len_sat;
  logic [CodeW-1:0]    code_mask;
  logic [EntW-1:0]     ent_wdata;
  logic [EntW-1:0]     ent_rdata;
  logic [LenW-1:0]     rd_len;
  logic [CodeW-1:0]    rd_code;

  logic [TblDepth-1:0] entry_valid_q, entry_valid_d;
  logic                s1_valid_q, s1_valid_d;
  logic [1:0]          s1_op_q;
  logic [ZeroW-1:0]    s1_zeros_q;
  logic                s1_hit_q;

  logic [ByteW-1:0]    acc_q, acc_d;
  logic [2:0]          pos_q, pos_d;

  logic                miss;
  logic [CntW-1:0]     n_bits;
  logic [CodeW-1:0]    bits;
  logic [CntW-1:0]     total;
  logic [CntW-1:0]     shamt;
  logic [WinW-1:0]     window;
  logic [1:0]          n_bytes;
  logic [1:0]          n_wr;
  out_word_t           w0, w1;

  out_word_t           q_mem_q [QDepth];
  logic [QPtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]    cnt_q, cnt_d;
  logic                pop;

  assign accept = in_i.valid & in_i.ready;
  assign s1_go  = cnt_q <= QCntW'(QDepth - 2);
  assign in_i.ready = !s1_valid_q || s1_go;

  // table write and read path
  always_comb begin
    if (in_i.code_length > LenInW'(CodeW)) begin
      len_sat = LenW'(CodeW);
    end else begin
      len_sat = LenW'(in_i.code_length);
    end
  end

  assign code_mask = ~({CodeW{1'b1}} << len_sat);
  assign ent_wdata = {len_sat, in_i.code_value[CodeW-1:0] & code_mask};

  hcbp_ram #(
    .Width(EntW),
    .Depth(TblDepth)
  ) u_code_ram (
    .clk_i  (clk_i),
    .we_i   (accept && (in_i.opcode == OP_LOAD)),
    .waddr_i(in_i.symbol),
    .wdata_i(ent_wdata),
    .re_i   (accept && (in_i.opcode == OP_ENCODE)),
    .raddr_i(in_i.symbol),
    .rdata_o(ent_rdata)
  );

  assign rd_len  = ent_rdata[EntW-1:CodeW];
  assign rd_code = ent_rdata[CodeW-1:0];

  always_comb begin
    entry_valid_d = entry_valid_q;
    if (accept && (in_i.opcode == OP_LOAD)) begin
      entry_valid_d[in_i.symbol] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = (in_i.opcode == OP_ENCODE) || (in_i.opcode == OP_ZERO_FILL);
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      s1_valid_q    <= 1'b0;
    end else begin
      entry_valid_q <= entry_valid_d;
      s1_valid_q    <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q    <= in_i.opcode;
      s1_zeros_q <= in_i.zero_count;
      s1_hit_q   <= entry_valid_q[in_i.symbol];
    end
  end

  // merge new bits into the accumulator window
  assign miss = (s1_op_q == OP_ENCODE) && !s1_hit_q;

  always_comb begin
    case (s1_op_q)
      OP_ENCODE: begin
        n_bits = s1_hit_q ? CntW'(rd_len) : '0;
        bits   = s1_hit_q ? rd_code : '0;
      end
      OP_ZERO_FILL: begin
        n_bits = CntW'(s1_zeros_q);
        bits   = '0;
      end
      default: begin
        n_bits = '0;
        bits   = '0;
      end
    endcase
  end

  assign total   = CntW'(pos_q) + n_bits;
  assign shamt   = CntW'(WinW) - CntW'(pos_q) - n_bits;
  assign window  = {acc_q, (WinW - ByteW)'(0)} | (WinW'(bits) << shamt);
  assign n_bytes = miss ? 2'd1 : total[4:3];
  assign n_wr    = (s1_valid_q && s1_go) ? n_bytes : 2'd0;

  always_comb begin
    w0.packed_byte    = miss ? '0 : window[WinW-1 -: ByteW];
    w0.last_of_run    = miss || (n_bytes == 2'd1);
    w0.symbol_missing = miss;
    w1.packed_byte    = window[WinW-ByteW-1 -: ByteW];
    w1.last_of_run    = 1'b1;
    w1.symbol_missing = 1'b0;
  end

  always_comb begin
    acc_d = acc_q;
    pos_d = pos_q;
    if (s1_valid_q && s1_go && !miss) begin
      pos_d = total[2:0];
      case (total[4:3])
        2'd0:    acc_d = window[WinW-1 -: ByteW];
        2'd1:    acc_d = window[WinW-ByteW-1 -: ByteW];
        default: acc_d = window[ByteW-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      pos_q <= '0;
    end else begin
      acc_q <= acc_d;
      pos_q <= pos_d;
    end
  end

  // output queue
  assign pop   = out_o.valid & out_o.ready;
  assign cnt_d = cnt_q + QCntW'(n_wr) - QCntW'(pop);

  always_ff @(posedge clk_i) begin
    if (n_wr != 2'd0) begin
      q_mem_q[wr_ptr_q] <= w0;
    end
    if (n_wr == 2'd2) begin
      q_mem_q[QPtrW'(wr_ptr_q + 1'b1)] <= w1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPtrW'(n_wr);
      rd_ptr_q <= rd_ptr_q + QPtrW'(pop);
      cnt_q    <= cnt_d;
    end
  end

  assign out_o.valid          = cnt_q != '0;
  assign out_o.packed_byte    = q_mem_q[rd_ptr_q].packed_byte;
  assign out_o.last_of_run    = q_mem_q[rd_ptr_q].last_of_run;
  assign out_o.symbol_missing = q_mem_q[rd_ptr_q].symbol_missing;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("output queue overflow");

  a_window_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_go) |-> (total < CntW'(WinW)))
    else $error("merged bits exceed window");

  a_encode_staged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.opcode == OP_ENCODE)) |=> s1_valid_q)
    else $error("encode word not staged");

  a_miss_holds_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_go && miss) |=> ($stable(pos_q) && $stable(acc_q)))
    else $error("missing symbol changed accumulator");
`endif

endmodule
